/* rtl/cg_pkg.sv */
package cg_pkg;

    localparam int MAX_N_DEF = 8;
    localparam int MAX_R_DEF = 3;
    localparam int NUM_PICKS = 3;
    localparam int DATA_W    = 32;
    localparam int CHOOSE_W  = 2;

    localparam logic [CHOOSE_W-1:0] CHOOSE_RST = 2'd3;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic too_few;
    } t_status;

endpackage

/* rtl/cg_ram.sv */
module cg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cg_ctrl.sv */
module cg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_is_last,
    input  cg_pkg::t_status  i_status,
    output logic             o_busy,
    output cg_pkg::t_cmd     o_cmd
);
    import cg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_GEN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                cmd.load = i_start;
                cmd.init = i_start & i_is_last;
                if (cmd.init) begin
                    n_state = S_GEN;
                end
            end
            S_GEN: begin
                if (i_status.too_few) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    cmd.step = 1'b1;
                    if (i_status.done) begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

endmodule

/* rtl/cg_dpath.sv */
module cg_dpath #(
    parameter int MAX_N = cg_pkg::MAX_N_DEF,
    parameter int MAX_R = cg_pkg::MAX_R_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cg_pkg::t_cmd                        i_cmd,
    input  logic                                i_cfg_we,
    input  logic [cg_pkg::CHOOSE_W-1:0]         i_cfg_wdata,
    input  logic signed [cg_pkg::DATA_W-1:0]    i_element_value,
    output cg_pkg::t_status                     o_status,
    output logic                                o_strobe,
    output logic signed [cg_pkg::DATA_W-1:0]    o_first_pick,
    output logic signed [cg_pkg::DATA_W-1:0]    o_second_pick,
    output logic signed [cg_pkg::DATA_W-1:0]    o_third_pick,
    output logic                                o_overflow_seen,
    output logic                                o_last_of_run
);
    import cg_pkg::*;

    localparam int CW = $clog2(MAX_N + 1);
    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int SW = CW + 2;
    localparam int PW = $clog2(NUM_PICKS);

    logic [CHOOSE_W-1:0] r_choose;
    logic [CHOOSE_W-1:0] r_r;
    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [IW-1:0]       r_idx [NUM_PICKS];
    logic [IW-1:0]       n_idx [NUM_PICKS];
    logic                r_emit;
    logic                r_last;
    logic                r_ovf_out;

    logic                found;
    logic [PW-1:0]       pos;
    logic [SW-1:0]       base;
    logic                wr_en;
    logic [DATA_W-1:0]   rdata [NUM_PICKS];

    assign wr_en = i_cmd.load && (r_count < CW'(MAX_N));

    // rightmost index that can still advance; later lanes follow it
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int t = 0; t < NUM_PICKS; t++) begin
            if ((CHOOSE_W'(t) < r_r) &&
                (SW'(r_idx[t]) + SW'(r_r) < SW'(r_count) + SW'(t))) begin
                found = 1'b1;
                pos   = PW'(t);
            end
        end
        base = SW'(r_idx[pos]) + SW'(1);
        for (int j = 0; j < NUM_PICKS; j++) begin
            n_idx[j] = r_idx[j];
            if (found && (PW'(j) >= pos)) begin
                n_idx[j] = IW'(base + SW'(j) - SW'(pos));
            end
        end
    end

    assign o_status.done    = !found;
    assign o_status.too_few = SW'(r_r) > SW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_choose  <= CHOOSE_RST;
            r_r       <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_emit    <= 1'b0;
            r_last    <= 1'b0;
            r_ovf_out <= 1'b0;
            for (int j = 0; j < NUM_PICKS; j++) begin
                r_idx[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_choose <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (r_count < CW'(MAX_N)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.init) begin
                r_r <= (r_choose > CHOOSE_W'(MAX_R)) ? CHOOSE_W'(MAX_R) : r_choose;
                for (int j = 0; j < NUM_PICKS; j++) begin
                    r_idx[j] <= IW'(j);
                end
            end else if (i_cmd.step) begin
                r_idx <= n_idx;
            end
            r_emit    <= i_cmd.step;
            r_last    <= !found;
            r_ovf_out <= r_ovf;
        end
    end

    // one store copy per pick lane below MAX_R so each has its own read port; other lanes read zero
    for (genvar g = 0; g < NUM_PICKS; g++) begin : g_lane
        if (g < MAX_R) begin : g_ram
            cg_ram #(
                .WIDTH (DATA_W),
                .DEPTH (MAX_N),
                .AW    (IW)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (wr_en),
                .i_waddr (r_count[IW-1:0]),
                .i_wdata (i_element_value),
                .i_raddr (r_idx[g]),
                .o_rdata (rdata[g])
            );
        end else begin : g_zero
            assign rdata[g] = '0;
        end
    end

    assign o_strobe        = r_emit;
    assign o_first_pick    = (r_r > CHOOSE_W'(0)) ? rdata[0] : '0;
    assign o_second_pick   = (r_r > CHOOSE_W'(1)) ? rdata[1] : '0;
    assign o_third_pick    = (r_r > CHOOSE_W'(2)) ? rdata[2] : '0;
    assign o_overflow_seen = r_ovf_out;
    assign o_last_of_run   = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_N))
        else $error("element count above store depth");

    a_idx_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && (r_r >= CHOOSE_W'(2))) |-> (r_idx[0] < r_idx[1]))
        else $error("pick indices out of order");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emit && r_last) |=> !r_emit)
        else $error("strobe right after final transaction of a run");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> ((r_count == '0) && !r_ovf))
        else $error("store not emptied after run");
`endif

endmodule

/* rtl/combination_generator_top.sv */
// Channel   Handshake                      Payload
// input     start & !busy                  i_element_value, i_is_last
// config    i_cfg_we                       i_cfg_wdata (choose count)
// result    o_strobe, one cycle            o_first_pick, o_second_pick, o_third_pick,
//                                          o_overflow_seen, o_last_of_run
//
// A transaction with i_is_last set holds busy while it emits C(n,r)
// results (one per combination), or emits no result if r > n;
// the store read port per pick lane sets one combination per cycle.
// Results appear the cycle after the index registers hold them (registered store read).
// Synchronous active-low reset; choose count resets to 3.
// The receiver cannot stall; every strobe is a completed transaction.
module combination_generator_top #(
    parameter int MAX_N = cg_pkg::MAX_N_DEF,
    parameter int MAX_R = cg_pkg::MAX_R_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cg_pkg::DATA_W-1:0]    i_element_value,
    input  logic                                i_is_last,
    input  logic                                i_cfg_we,
    input  logic [cg_pkg::CHOOSE_W-1:0]         i_cfg_wdata,
    output logic                                o_strobe,
    output logic signed [cg_pkg::DATA_W-1:0]    o_first_pick,
    output logic signed [cg_pkg::DATA_W-1:0]    o_second_pick,
    output logic signed [cg_pkg::DATA_W-1:0]    o_third_pick,
    output logic                                o_overflow_seen,
    output logic                                o_last_of_run
);
    import cg_pkg::*;

    t_cmd    cmd;
    t_status status;

    cg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_is_last),
        .i_status  (status),
        .o_busy    (busy),
        .o_cmd     (cmd)
    );

    cg_dpath #(
        .MAX_N (MAX_N),
        .MAX_R (MAX_R)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_element_value (i_element_value),
        .o_status        (status),
        .o_strobe        (o_strobe),
        .o_first_pick    (o_first_pick),
        .o_second_pick   (o_second_pick),
        .o_third_pick    (o_third_pick),
        .o_overflow_seen (o_overflow_seen),
        .o_last_of_run   (o_last_of_run)
    );

endmodule
